// ===== sv/lse_pkg.sv =====
// lse_pkg: shared constants and types for the lsb stego extractor
// mode and register codes, header geometry, bit and result structs
// no dependencies
package lse_pkg;

  localparam int LENGTH_BYTES = 4;
  localparam int LEN_BITS     = LENGTH_BYTES * 8;
  localparam int CNT_W        = 6;
  localparam int LEN_W        = 32;
  localparam int BYTE_W       = 8;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 2;

  localparam logic [MODE_W-1:0] MODE_LSB1 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LSB4 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LSBI = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_EMBED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_READ_EXT   = 1'd1;

  // hidden bits pulled from one carrier byte, msb first when four wide
  typedef struct packed {
    logic       four;
    logic [3:0] bits;
  } bits_t;

  // restart request and mode flags towards the frame controller
  typedef struct packed {
    logic restart;
    logic lsbi;
    logic read_ext;
  } ctl_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
    logic              section;
    logic              last;
    logic [LEN_W-1:0]  payload_length;
  } result_t;

endpackage

// ===== sv/lse_bit_unpack.sv =====
// lse_bit_unpack: pulls the hidden bits out of one carrier byte
// applies the pattern inversion mask in lsbi mode
// depends on lse_pkg
module lse_bit_unpack (
  input  logic [lse_pkg::BYTE_W-1:0] carrier,
  input  logic [lse_pkg::MODE_W-1:0] embed_mode,
  input  logic [3:0]                 invert_mask,
  output lse_pkg::bits_t             bits
);

  logic [1:0] pat;

  assign pat = carrier[2:1];

  always_comb begin
    bits.four = 1'b0;
    bits.bits = 4'd0;
    unique case (embed_mode)
      lse_pkg::MODE_LSB4: begin
        bits.four = 1'b1;
        bits.bits = carrier[3:0];
      end
      lse_pkg::MODE_LSBI: begin
        bits.bits = {3'd0, carrier[0] ^ invert_mask[pat]};
      end
      default: begin
        bits.bits = {3'd0, carrier[0]};
      end
    endcase
  end

endmodule

// ===== sv/lse_frame_ctrl.sv =====
// lse_frame_ctrl: header, length, payload and extension sequencing
// holds shift register, counters and inversion mask; builds the result
// depends on lse_pkg
module lse_frame_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lse_pkg::ctl_t         ctl,
  input  logic                  step,
  input  lse_pkg::bits_t        bits,
  output logic [3:0]            invert_mask,
  output lse_pkg::result_t      res
);

  typedef enum logic [2:0] {
    PH_PATTERN,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_EXTENSION,
    PH_DONE
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic [lse_pkg::CNT_W-1:0]     bit_count_r, bit_count_nxt;
  logic [lse_pkg::LEN_W-1:0]     shift_r, shift_nxt;
  logic [lse_pkg::LEN_W-1:0]     length_r, length_nxt;
  logic [lse_pkg::LEN_W-1:0]     remaining_r, remaining_nxt;
  logic [3:0]                    mask_r, mask_nxt;

  logic [lse_pkg::LEN_W-1:0]     shift_add;
  logic [lse_pkg::CNT_W-1:0]     cnt_add;
  logic [lse_pkg::LEN_W-1:0]     remaining_dec;

  assign shift_add = bits.four ? {shift_r[lse_pkg::LEN_W-5:0], bits.bits}
                               : {shift_r[lse_pkg::LEN_W-2:0], bits.bits[0]};
  assign cnt_add   = bit_count_r + (bits.four ? lse_pkg::CNT_W'(4) : lse_pkg::CNT_W'(1));
  assign remaining_dec = remaining_r - lse_pkg::LEN_W'(1);
  assign invert_mask   = mask_r;

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = cnt_add;
    shift_nxt     = shift_add;
    length_nxt    = length_r;
    remaining_nxt = remaining_r;
    mask_nxt      = mask_r;
    res.valid          = 1'b0;
    res.data_byte      = shift_add[lse_pkg::BYTE_W-1:0];
    res.section        = 1'b0;
    res.last           = 1'b0;
    res.payload_length = length_r;
    unique case (phase_r)
      PH_PATTERN: begin
        if (cnt_add == lse_pkg::CNT_W'(4)) begin
          // first extracted bit lands in mask bit 0
          mask_nxt      = {shift_add[0], shift_add[1], shift_add[2], shift_add[3]};
          bit_count_nxt = '0;
          shift_nxt     = '0;
          phase_nxt     = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        if (cnt_add == lse_pkg::CNT_W'(lse_pkg::LEN_BITS)) begin
          length_nxt    = shift_add;
          remaining_nxt = shift_add;
          bit_count_nxt = '0;
          shift_nxt     = '0;
          if (shift_add != '0) begin
            phase_nxt = PH_PAYLOAD;
          end else begin
            phase_nxt = ctl.read_ext ? PH_EXTENSION : PH_DONE;
          end
        end
      end
      PH_PAYLOAD: begin
        if (cnt_add == lse_pkg::CNT_W'(8)) begin
          res.valid     = 1'b1;
          bit_count_nxt = '0;
          shift_nxt     = '0;
          remaining_nxt = remaining_dec;
          if (remaining_dec == '0) begin
            if (ctl.read_ext) begin
              phase_nxt = PH_EXTENSION;
            end else begin
              phase_nxt = PH_DONE;
              res.last  = 1'b1;
            end
          end
        end
      end
      PH_EXTENSION: begin
        if (cnt_add == lse_pkg::CNT_W'(8)) begin
          res.valid     = 1'b1;
          res.section   = 1'b1;
          bit_count_nxt = '0;
          shift_nxt     = '0;
          if (shift_add[lse_pkg::BYTE_W-1:0] == '0) begin
            phase_nxt = PH_DONE;
            res.last  = 1'b1;
          end
        end
      end
      default: begin
        // finished: carrier bytes are swallowed
        bit_count_nxt = bit_count_r;
        shift_nxt     = shift_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LENGTH;
      bit_count_r <= '0;
      shift_r     <= '0;
      length_r    <= '0;
      remaining_r <= '0;
      mask_r      <= '0;
    end else if (ctl.restart) begin
      phase_r     <= ctl.lsbi ? PH_PATTERN : PH_LENGTH;
      bit_count_r <= '0;
      shift_r     <= '0;
      length_r    <= '0;
      remaining_r <= '0;
      mask_r      <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      length_r    <= length_nxt;
      remaining_r <= remaining_nxt;
      mask_r      <= mask_nxt;
    end
  end

endmodule

// ===== sv/lsb_stego_extractor.sv =====
// lsb_stego_extractor: a carrier byte passes the input register, then the result register
// throughput one carrier byte per cycle while in_stall is low; an input register feeds the bit
// unpack and frame sequencer, which load the result register in one pass
// a byte that completes no result moves on even while a result is stalled
// synchronous active-low reset: lsb1 mode, extension off, length phase
module lsb_stego_extractor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [lse_pkg::BYTE_W-1:0]     in_carrier_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [lse_pkg::BYTE_W-1:0]     out_data_byte,
  output logic                           out_section,
  output logic                           out_last,
  output logic [lse_pkg::LEN_W-1:0]      out_payload_length
);

  logic [lse_pkg::MODE_W-1:0] embed_mode_r;
  logic                       read_ext_r;
  logic [lse_pkg::MODE_W-1:0] mode_after;
  logic                       ext_after;

  logic                       s1_valid_r;
  logic [lse_pkg::BYTE_W-1:0] s1_carrier_r;
  logic                       s1_go;
  logic                       in_take;

  logic                       out_valid_r;
  logic [lse_pkg::BYTE_W-1:0] out_data_r;
  logic                       out_section_r;
  logic                       out_last_r;
  logic [lse_pkg::LEN_W-1:0]  out_length_r;

  lse_pkg::ctl_t    ctl;
  lse_pkg::bits_t   bits;
  lse_pkg::result_t res;
  logic [3:0]       invert_mask;

  // restart uses the embed mode as it stands after this write
  always_comb begin
    mode_after = embed_mode_r;
    ext_after  = read_ext_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lse_pkg::REG_EMBED_MODE: mode_after = cfg_wdata;
        lse_pkg::REG_READ_EXT:   ext_after  = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign ctl.restart  = cfg_we;
  assign ctl.lsbi     = (mode_after == lse_pkg::MODE_LSBI);
  assign ctl.read_ext = read_ext_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      embed_mode_r <= lse_pkg::MODE_LSB1;
      read_ext_r   <= 1'b0;
    end else begin
      embed_mode_r <= mode_after;
      read_ext_r   <= ext_after;
    end
  end

  lse_bit_unpack u_unpack (
    .carrier     (s1_carrier_r),
    .embed_mode  (embed_mode_r),
    .invert_mask (invert_mask),
    .bits        (bits)
  );

  lse_frame_ctrl u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .step        (s1_go),
    .bits        (bits),
    .invert_mask (invert_mask),
    .res         (res)
  );

  // a completing byte needs the result slot free or draining
  assign s1_go    = s1_valid_r && (!res.valid || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_carrier_r <= in_carrier_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res.valid) begin
      out_data_r    <= res.data_byte;
      out_section_r <= res.section;
      out_last_r    <= res.last;
      out_length_r  <= res.payload_length;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_data_byte      = out_data_r;
  assign out_section        = out_section_r;
  assign out_last           = out_last_r;
  assign out_payload_length = out_length_r;

  a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && res.valid) |=> out_valid)
    else $error("completed byte did not reach the result register");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && res.valid && out_valid_r))
    else $error("input stalled without a blocked result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(s1_go && res.valid))
    else $error("stalled result overwritten");

endmodule
